@@ hdl/zbgp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbgp_pkg
// Shared widths and control structs for the zero byte group packer.
// ----------------------------------------------------------------------------
package zbgp_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 32;

    // job handed from the collector to the emitter
    typedef struct packed {
        logic load;
        logic hdr;
        logic grp;
        logic fin;
    } job_ctl_t;

    // collector status seen by the top level
    typedef struct packed {
        logic hdr_done;
        logic yields;
    } col_stat_t;

endpackage

@@ hdl/zbgp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbgp_in_if
// Input byte channel: raw stream byte and final flag.
// ----------------------------------------------------------------------------
interface zbgp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

@@ hdl/zbgp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbgp_out_if
// Output byte channel: packed byte with per-job and end-of-stream marks.
// ----------------------------------------------------------------------------
interface zbgp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output out_byte, output run_last, output stream_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_end,
                    output ready);
endinterface

@@ hdl/zbgp_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbgp_cfg_if
// Configuration write channel for the total length register.
// ----------------------------------------------------------------------------
interface zbgp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] total_length;

    modport source (output valid, output total_length, input ready);
    modport sink   (input valid, input total_length, output ready);
endinterface

@@ hdl/zbgp_collector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbgp_collector
// Gathers input bytes into a group with its nonzero mask and hands a job
// to the emitter when a header is due or a group completes.
// ----------------------------------------------------------------------------
module zbgp_collector #(
    parameter int GROUP_BYTES = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    zbgp_in_if.sink                      ingress,
    input  logic                         slot_free,
    output zbgp_pkg::job_ctl_t           job_ctl,
    output logic [GROUP_BYTES-1:0]       job_mask,
    output logic [GROUP_BYTES-1:0][7:0]  job_bytes,
    output zbgp_pkg::col_stat_t          stat
);
    import zbgp_pkg::*;

    localparam int GIW = (GROUP_BYTES > 1) ? $clog2(GROUP_BYTES) : 1;

    logic [GROUP_BYTES-1:0][7:0] bytes_reg;
    logic [GROUP_BYTES-1:0]      mask_reg;
    logic [GROUP_BYTES-1:0]      mask_next;
    logic [GIW-1:0]              fill_reg;
    logic                        hdr_done_reg;
    logic                        nz;
    logic                        complete;
    logic                        yields;
    logic                        accept;

    assign nz       = (ingress.data_byte != 8'd0);
    assign complete = (fill_reg == GIW'(GROUP_BYTES - 1)) || ingress.final_byte;
    assign yields   = !hdr_done_reg || complete;
    assign ingress.ready = !yields || slot_free;
    assign accept   = ingress.valid && ingress.ready;

    always_comb
    begin
        for (int k = 0; k < GROUP_BYTES; k++)
        begin
            mask_next[k] = mask_reg[k] | ((fill_reg == GIW'(k)) && nz);
            job_bytes[k] = (fill_reg == GIW'(k)) ? ingress.data_byte : bytes_reg[k];
        end
    end

    assign job_mask     = mask_next;
    assign job_ctl.load = accept && yields;
    assign job_ctl.hdr  = !hdr_done_reg;
    assign job_ctl.grp  = complete;
    assign job_ctl.fin  = ingress.final_byte;

    assign stat.hdr_done = hdr_done_reg;
    assign stat.yields   = yields;

    always_ff @(posedge clk)
    begin
        if (accept && !complete)
        begin
            bytes_reg[fill_reg] <= ingress.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            fill_reg     <= '0;
            hdr_done_reg <= 1'b0;
        end
        else if (accept)
        begin
            hdr_done_reg <= !ingress.final_byte;
            if (complete)
            begin
                mask_reg <= '0;
                fill_reg <= '0;
            end
            else
            begin
                mask_reg <= mask_next;
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

endmodule

@@ hdl/zbgp_emitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbgp_emitter
// Holds one job and sends it out a beat at a time: header bytes if due, then
// for a group the mask byte and its nonzero bytes lowest position first.
// ----------------------------------------------------------------------------
module zbgp_emitter #(
    parameter int GROUP_BYTES  = 8,
    parameter int HEADER_BYTES = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  zbgp_pkg::job_ctl_t           job_ctl,
    input  logic [GROUP_BYTES-1:0]       job_mask,
    input  logic [GROUP_BYTES-1:0][7:0]  job_bytes,
    input  logic [31:0]                  total_length,
    output logic                         slot_free,
    zbgp_out_if.source                   egress
);
    import zbgp_pkg::*;

    localparam int GIW = (GROUP_BYTES > 1) ? $clog2(GROUP_BYTES) : 1;
    localparam int HCW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int HW  = HEADER_BYTES * BYTE_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HDR  = 2'd1;
    localparam logic [1:0] S_MASK = 2'd2;
    localparam logic [1:0] S_DATA = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [HCW-1:0]              hdr_cnt_reg;
    logic [HCW-1:0]              hdr_cnt_next;
    logic                        grp_reg;
    logic                        fin_reg;
    logic [GROUP_BYTES-1:0]      mask_reg;
    logic [GROUP_BYTES-1:0]      mask_next;
    logic [GROUP_BYTES-1:0][7:0] bytes_reg;
    logic [HW-1:0]               hdr_word;
    logic [GIW-1:0]              sel;
    logic                        last_beat;
    logic                        beat;

    generate
        if (HW <= LEN_W)
        begin : g_hdr_trunc
            assign hdr_word = total_length[HW-1:0];
        end
        else
        begin : g_hdr_ext
            assign hdr_word = {{(HW - LEN_W){1'b0}}, total_length};
        end
    endgenerate

    // lowest set bit of the remaining mask
    always_comb
    begin
        sel = '0;
        for (int k = GROUP_BYTES - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
            begin
                sel = GIW'(k);
            end
        end
    end

    always_comb
    begin
        egress.out_byte = 8'd0;
        last_beat       = 1'b0;
        unique case (state_reg)
            S_HDR:
            begin
                egress.out_byte = hdr_word[{hdr_cnt_reg, 3'b000} +: 8];
                last_beat       = (hdr_cnt_reg == '0) && !grp_reg;
            end
            S_MASK:
            begin
                egress.out_byte = 8'(mask_reg);
                last_beat       = (mask_reg == '0);
            end
            S_DATA:
            begin
                egress.out_byte = bytes_reg[sel];
                last_beat       = ((mask_reg & (mask_reg - 1'b1)) == '0);
            end
            default:
            begin
                egress.out_byte = 8'd0;
                last_beat       = 1'b0;
            end
        endcase
    end

    assign egress.valid      = (state_reg != S_IDLE);
    assign egress.run_last   = last_beat;
    assign egress.stream_end = last_beat && fin_reg;
    assign beat      = egress.valid && egress.ready;
    assign slot_free = (state_reg == S_IDLE) || (beat && last_beat);

    always_comb
    begin
        state_next   = state_reg;
        hdr_cnt_next = hdr_cnt_reg;
        mask_next    = mask_reg;
        if (beat)
        begin
            unique case (state_reg)
                S_HDR:
                begin
                    if (hdr_cnt_reg == '0)
                    begin
                        state_next = grp_reg ? S_MASK : S_IDLE;
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg - 1'b1;
                    end
                end
                S_MASK:
                begin
                    state_next = (mask_reg == '0) ? S_IDLE : S_DATA;
                end
                S_DATA:
                begin
                    mask_next = mask_reg & (mask_reg - 1'b1);
                    if (last_beat)
                    begin
                        state_next = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
        if (job_ctl.load)
        begin
            state_next   = job_ctl.hdr ? S_HDR : S_MASK;
            hdr_cnt_next = HCW'(HEADER_BYTES - 1);
            mask_next    = job_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_ctl.load)
        begin
            bytes_reg <= job_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            hdr_cnt_reg <= '0;
            mask_reg    <= '0;
            grp_reg     <= 1'b0;
            fin_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hdr_cnt_reg <= hdr_cnt_next;
            mask_reg    <= mask_next;
            if (job_ctl.load)
            begin
                grp_reg <= job_ctl.grp;
                fin_reg <= job_ctl.fin;
            end
        end
    end

endmodule

@@ hdl/zero_byte_group_packer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_byte_group_packer_core
// Packs a byte stream into a length header followed by mask-plus-nonzero
// byte groups.
// ----------------------------------------------------------------------------
// Input bytes are taken one per cycle unless a byte waits for the job slot.
// A byte that completes nothing is taken at once; a byte that starts a
// stream or closes a group hands a job to the single output job slot and is
// taken when that slot is empty or frees on the same edge. The slot sends
// one beat per cycle while egress is ready: HEADER_BYTES header beats at
// stream start, then one mask beat plus one beat per nonzero byte of the
// group, and the output beat rate sets the pace.
module zero_byte_group_packer_core #(
    parameter int GROUP_BYTES  = 8,
    parameter int HEADER_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    zbgp_cfg_if.sink    cfg,
    zbgp_in_if.sink     ingress,
    zbgp_out_if.source  egress
);
    import zbgp_pkg::*;

    logic [31:0]                 total_length_reg;
    logic                        slot_free;
    job_ctl_t                    job_ctl;
    col_stat_t                   stat;
    logic [GROUP_BYTES-1:0]      job_mask;
    logic [GROUP_BYTES-1:0][7:0] job_bytes;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_length_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            total_length_reg <= cfg.total_length;
        end
    end

    zbgp_collector #(
        .GROUP_BYTES (GROUP_BYTES)
    ) u_collector (
        .clk       (clk),
        .rst_n     (rst_n),
        .ingress   (ingress),
        .slot_free (slot_free),
        .job_ctl   (job_ctl),
        .job_mask  (job_mask),
        .job_bytes (job_bytes),
        .stat      (stat)
    );

    zbgp_emitter #(
        .GROUP_BYTES  (GROUP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_ctl      (job_ctl),
        .job_mask     (job_mask),
        .job_bytes    (job_bytes),
        .total_length (total_length_reg),
        .slot_free    (slot_free),
        .egress       (egress)
    );

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        egress.valid && egress.stream_end |-> egress.run_last)
        else $error("stream end without run last");

    a_final_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ingress.valid && ingress.ready && ingress.final_byte |=> egress.valid)
        else $error("final byte left no output");

    a_header_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ingress.valid && ingress.ready && !stat.hdr_done |=> egress.valid)
        else $error("stream start left no header");

    a_yield_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ingress.valid && ingress.ready && stat.yields |-> slot_free)
        else $error("job handed to a busy slot");

endmodule
